// File: hw/rtl/lpd_pkg.sv
// Shared definitions for the length-prefix deframer.
// Holds the request mode codes, buffer sizing defaults and register reset value.
// No dependencies.
package lpd_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int PREFIX_BYTES     = 4;

    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CAPACITY_RESET = 8'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_POLL   = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

endpackage

// File: hw/rtl/lpd_ram.sv
// Generic single-port RAM with a registered read.
// Used for the deframer byte buffer; depends on nothing.
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/lpd_ring_add.sv
// Shared ring-pointer adder: the buffer head plus an offset, wrapped at the depth.
// Every buffer address and head advance of the deframer goes through this unit.
// Depends on nothing.
module lpd_ring_add #(
    parameter int DEPTH = 64
) (
    input  logic [$clog2(DEPTH)-1:0]   base,
    input  logic [$clog2(DEPTH+1)-1:0] off,
    output logic [$clog2(DEPTH)-1:0]   sum
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0] DEPTH_W = (CNT_W + 1)'(DEPTH);

    logic [CNT_W:0] raw;
    logic [CNT_W:0] wrapped;

    always_comb begin
        raw     = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        wrapped = (raw >= DEPTH_W) ? raw - DEPTH_W : raw;
        sum     = wrapped[PTR_W-1:0];
    end

endmodule

// File: hw/rtl/length_prefix_deframer_unit.sv
// Length-prefix deframer top level: sequencer, ring buffer and output register.
// Depends on lpd_pkg, lpd_ram and lpd_ring_add.
//
// The slave channel carries one request per byte event: s_tuser holds the mode
// (append, poll, flush) and s_tdata the byte used by an append. Bytes are kept
// in a circular buffer. Frames start with a 4-byte big-endian payload length.
// When a complete frame fits the configured capacity, its payload leaves on the
// master channel one byte per request, m_tlast marking the final byte; a
// zero-length payload gives one request with m_tuser set and m_tlast set.
// cfg_we writes the receiver capacity; zero makes append and poll requests inert.
// Sequencing: a flush, an ignored request or an append that leaves fewer than four
// bytes completes in the idle state. Any other append or poll reads the four prefix
// bytes through the single RAM port before deciding. Each payload byte costs a RAM
// read and an output load and then waits for m_tready; ST_DROP removes the frame.
// s_tready is high only while the sequencer is idle. If the receiver stalls,
// the payload byte holds in the output register and the sequencer waits.
// After reset the buffer is empty and the capacity is 64; no clearing pass runs.
module length_prefix_deframer_unit
    import lpd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic [MODE_W-1:0] s_tuser,   // [1:0] mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] payload_byte
    output logic              m_tlast,
    output logic [0:0]        m_tuser,   // [0] empty_frame
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata
);

    localparam int PTR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0]  PREFIX_CNT = CNT_W'(PREFIX_BYTES);
    localparam logic [CNT_W-1:0]  ONE_CNT    = CNT_W'(1);
    localparam logic [BYTE_W-1:0] MAX_PLEN   = BYTE_W'(BUFFER_BYTES - PREFIX_BYTES);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_PREFIX    = 7'b0000010,
        ST_DECIDE    = 7'b0000100,
        ST_EMIT_RD   = 7'b0001000,
        ST_EMIT_LD   = 7'b0010000,
        ST_EMIT_WAIT = 7'b0100000,
        ST_DROP      = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   frame_reg, frame_next;
    logic               pend_reg, pend_next;
    logic [1:0]         pidx_reg, pidx_next;
    logic               hinz_reg, hinz_next;
    logic [BYTE_W-1:0]  plen_lo_reg, plen_lo_next;
    logic [BYTE_W-1:0]  cap_reg;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic [CNT_W-1:0]   ring_off;
    logic [PTR_W-1:0]   ring_addr;
    logic               ram_we;
    logic [BYTE_W-1:0]  ram_rdata;
    logic [8:0]         frame_wide;
    logic [CNT_W-1:0]   frame_len;
    logic               too_big;
    mode_t              req_mode;

    lpd_ring_add #(
        .DEPTH (BUFFER_BYTES)
    ) u_ring_add (
        .base (head_reg),
        .off  (ring_off),
        .sum  (ring_addr)
    );

    lpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_BYTES)
    ) u_buf_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ring_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    assign req_mode   = mode_t'(s_tuser);
    assign frame_wide = {1'b0, plen_lo_reg} + 9'(PREFIX_BYTES);
    assign frame_len  = frame_wide[CNT_W-1:0];
    assign too_big    = hinz_reg || (plen_lo_reg > MAX_PLEN);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE:   ring_off = fill_reg;
            ST_DECIDE: ring_off = too_big ? ONE_CNT : frame_len;
            ST_DROP:   ring_off = frame_reg;
            default:   ring_off = idx_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        hinz_next      = hinz_reg;
        plen_lo_next   = plen_lo_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        ram_we         = 1'b0;

        if (pend_reg) begin
            if (pidx_reg == 2'd3) begin
                plen_lo_next = ram_rdata;
            end else if (ram_rdata != '0) begin
                hinz_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                idx_next  = '0;
                hinz_next = 1'b0;
                if (s_tvalid) begin
                    if (req_mode == MODE_FLUSH) begin
                        fill_next = '0;
                    end else if (req_mode inside {MODE_APPEND, MODE_POLL} && cap_reg != '0) begin
                        if (req_mode == MODE_APPEND) begin
                            if (fill_reg == FULL_CNT) begin
                                fill_next = '0;
                            end else begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + ONE_CNT;
                                if (fill_reg + ONE_CNT >= PREFIX_CNT) begin
                                    state_next = ST_PREFIX;
                                end
                            end
                        end else if (fill_reg >= PREFIX_CNT) begin
                            state_next = ST_PREFIX;
                        end
                    end
                end
            end
            ST_PREFIX: begin
                if (idx_reg != PREFIX_CNT) begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[1:0];
                    idx_next  = idx_reg + ONE_CNT;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                frame_next = frame_len;
                idx_next   = PREFIX_CNT;
                if (too_big) begin
                    head_next  = ring_addr;
                    fill_next  = fill_reg - ONE_CNT;
                    state_next = ST_IDLE;
                end else if (fill_reg < frame_len) begin
                    state_next = ST_IDLE;
                end else if (plen_lo_reg >= cap_reg) begin
                    head_next  = ring_addr;
                    fill_next  = fill_reg - frame_len;
                    state_next = ST_IDLE;
                end else if (plen_lo_reg == '0) begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = ST_EMIT_WAIT;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                out_valid_next = 1'b1;
                out_data_next  = ram_rdata;
                out_last_next  = (idx_reg + ONE_CNT == frame_reg);
                out_empty_next = 1'b0;
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = ST_DROP;
                    end else begin
                        idx_next   = idx_reg + ONE_CNT;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_DROP: begin
                head_next  = ring_addr;
                fill_next  = fill_reg - frame_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAPACITY_RESET;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        frame_reg     <= frame_next;
        pidx_reg      <= pidx_next;
        hinz_reg      <= hinz_next;
        plen_lo_reg   <= plen_lo_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    // A request is never taken while a payload byte is still offered.
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !m_tvalid)
        else $error("input accepted while output request pending");

    // The buffer never holds more bytes than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= FULL_CNT)
        else $error("fill count exceeds buffer depth");

    // An empty-frame request is always the final request of its frame.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("empty frame without last");

    // Delivering the final payload byte removes the frame in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> state_reg == ST_DROP)
        else $error("frame not removed after final byte");

endmodule
